@@ design/lcrd_pkg.sv @@
// package: shared constants and types for the lockset race detector
`timescale 1ns / 1ps
package lcrd_pkg;
   localparam int THREADS_DEF    = 4;
   localparam int ENTRIES_DEF    = 64;
   localparam int CLOCK_BITS_DEF = 32;
   localparam int CLOCK_INPUTS   = 4;
   localparam int LOCK_BITS      = 8;
   localparam int TAG_BITS       = 16;
   localparam int CMD_BITS       = 3;

   localparam logic [CMD_BITS-1:0] CMD_ACQUIRE = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_RELEASE = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ    = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_WRITE   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_FREE    = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE,
      ST_OWN,
      ST_SCAN,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;
endpackage

@@ design/lockset_clock_race_detector_unit.sv @@
// lockset plus vector-clock race detector: shared record memory and scan sequencer
// steps: lock, unknown and out-of-range requests go straight to the result; a read or write
// reads its own record, ends if redundant, else writes it and scans THREADS write records
// (read) or all 2*THREADS records (write), a read and a compare each; a free clears 2^(TB+1)
// records. One request at a time, req_tready only when idle, so a new request waits for the
// last result and any output stall; reset: lock counts clear at once; a clearing pass sets
// all 2^(EB+TB+1) records (512 at the defaults) to their reset value before requests are taken
`timescale 1ns / 1ps
module lockset_clock_race_detector_unit #(
   parameter int THREADS    = lcrd_pkg::THREADS_DEF,
   parameter int ENTRIES    = lcrd_pkg::ENTRIES_DEF,
   parameter int CLOCK_BITS = lcrd_pkg::CLOCK_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[2:0], thread[4:3], entry[10:5], instr_tag[26:11], clock_t0..t3[154:27], pad
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // race_found[0], prior_thread[2:1], prior_is_write[3], prior_tag[19:4],
   // current_tag[35:20], pad
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast
);
   localparam int TB    = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int EB    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IW    = TB + 1;
   localparam int TAG   = lcrd_pkg::TAG_BITS;
   localparam int LB    = lcrd_pkg::LOCK_BITS;
   localparam int AB    = EB + TB + 1;
   localparam int DEPTH = 1 << AB;
   localparam int RW    = CLOCK_BITS + 1 + TAG; // clock, unlocked, tag

   // record memory: address {entry, thread, is_write}
   logic [RW-1:0] mem [DEPTH];
   logic [RW-1:0] rd_ff;
   logic [AB-1:0] rd_addr;
   logic          wr_en;
   logic [AB-1:0] wr_addr;
   logic [RW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   lcrd_pkg::state_type state_ff, state_in;
   logic [LB-1:0] locks_ff [THREADS];
   logic [AB-1:0] clr_ff, clr_in;
   logic [IW-1:0] idx_ff, idx_in;     // scan position: writes 0..THREADS-1, then reads
   logic          pend_ff, pend_in;   // a race is held back until the next one or the end
   logic [35:0]   pend_data_ff, pend_data_in;

   logic [2:0]            cmd_ff;
   logic [TB-1:0]         thr_ff;
   logic [EB-1:0]         ent_ff;
   logic [TAG-1:0]        tag_ff;
   logic [CLOCK_BITS-1:0] vc_ff [THREADS];
   logic                  nolock_ff;

   logic [39:0] out_ff, out_in;
   logic        last_ff, last_in;
   logic        ovalid_ff, ovalid_in;

   logic [2:0]    in_cmd;
   logic [1:0]    in_thr;
   logic [5:0]    in_ent;
   logic          in_ok;
   logic [TB-1:0] in_t;

   assign in_cmd = req_tdata[2:0];
   assign in_thr = req_tdata[4:3];
   assign in_ent = req_tdata[10:5];
   assign in_t   = TB'(in_thr);
   assign in_ok  = (32'(in_thr) < 32'(THREADS)) && (32'(in_ent) < 32'(ENTRIES));

   logic accept;
   assign req_tready = (state_ff == lcrd_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = last_ff;

   logic is_wr;
   assign is_wr = (cmd_ff == lcrd_pkg::CMD_WRITE);

   logic          scan_rd;
   logic [TB-1:0] scan_thr;
   logic          scan_last;
   logic [AB-1:0] scan_addr;
   logic [AB-1:0] own_addr;
   assign scan_rd   = (idx_ff >= IW'(THREADS));
   assign scan_thr  = scan_rd ? TB'(idx_ff - IW'(THREADS)) : TB'(idx_ff);
   assign scan_last = (idx_ff == (is_wr ? IW'(2*THREADS-1) : IW'(THREADS-1)));
   assign scan_addr = {ent_ff, scan_thr, ~scan_rd};
   assign own_addr  = {ent_ff, thr_ff, is_wr};

   // compare of the record read last cycle
   logic [CLOCK_BITS-1:0] rec_clk;
   logic                  rec_unl;
   logic [TAG-1:0]        rec_tag;
   logic                  redundant;
   logic                  hit;
   logic                  out_free;
   logic                  check_stall;
   logic [35:0]           race_word;
   assign rec_clk   = rd_ff[RW-1 -: CLOCK_BITS];
   assign rec_unl   = rd_ff[TAG];
   assign rec_tag   = rd_ff[TAG-1:0];
   assign redundant = (rec_clk == vc_ff[thr_ff]) && (rec_unl || !nolock_ff);
   assign hit       = (scan_thr != thr_ff) && (rec_clk > vc_ff[scan_thr])
                      && (rec_unl || nolock_ff);
   assign out_free    = !ovalid_ff || rsp_tready;
   assign check_stall = hit && pend_ff && !out_free;
   assign race_word   = {tag_ff, rec_tag, ~scan_rd, 2'(scan_thr), 1'b1};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcrd_pkg::ST_CLEAR: if (&clr_ff) state_in = lcrd_pkg::ST_IDLE;
         lcrd_pkg::ST_IDLE: begin
            if (accept) begin
               if (!in_ok) begin
                  state_in = lcrd_pkg::ST_DONE;
               end else begin
                  unique case (in_cmd) inside
                     lcrd_pkg::CMD_READ, lcrd_pkg::CMD_WRITE: state_in = lcrd_pkg::ST_OWN;
                     lcrd_pkg::CMD_FREE: state_in = lcrd_pkg::ST_FREE;
                     default: state_in = lcrd_pkg::ST_DONE;
                  endcase
               end
            end
         end
         lcrd_pkg::ST_FREE: if (&clr_ff[TB:0]) state_in = lcrd_pkg::ST_DONE;
         lcrd_pkg::ST_OWN: state_in = lcrd_pkg::ST_SCAN;
         lcrd_pkg::ST_SCAN: state_in = redundant ? lcrd_pkg::ST_DONE : lcrd_pkg::ST_READ;
         lcrd_pkg::ST_READ: state_in = lcrd_pkg::ST_CHECK;
         lcrd_pkg::ST_CHECK: begin
            if (!check_stall) state_in = scan_last ? lcrd_pkg::ST_DONE : lcrd_pkg::ST_READ;
         end
         lcrd_pkg::ST_DONE: if (out_free) state_in = lcrd_pkg::ST_IDLE;
         default: state_in = lcrd_pkg::ST_IDLE;
      endcase
   end

   // memory control, scan position and result register
   always_comb begin
      rd_addr      = scan_addr;
      wr_en        = 1'b0;
      wr_addr      = own_addr;
      wr_data      = {vc_ff[thr_ff], nolock_ff, tag_ff};
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      out_in       = out_ff;
      last_in      = last_ff;
      ovalid_in    = ovalid_ff && !rsp_tready;
      unique case (state_ff)
         lcrd_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {{CLOCK_BITS{1'b0}}, 1'b1, {TAG{1'b0}}};
            clr_in  = clr_ff + 1'b1;
         end
         lcrd_pkg::ST_IDLE: begin
            clr_in  = '0;
            idx_in  = '0;
            pend_in = 1'b0;
         end
         lcrd_pkg::ST_FREE: begin
            // sweep the 2^(TB+1) records of one slot, 2*THREADS when THREADS is a power of two above one
            wr_en   = 1'b1;
            wr_addr = {ent_ff, clr_ff[TB:0]};
            wr_data = {{CLOCK_BITS{1'b0}}, 1'b1, {TAG{1'b0}}};
            clr_in  = clr_ff + 1'b1;
         end
         lcrd_pkg::ST_OWN: rd_addr = own_addr;
         lcrd_pkg::ST_SCAN: begin
            if (!redundant) wr_en = 1'b1;
         end
         lcrd_pkg::ST_READ: ;
         lcrd_pkg::ST_CHECK: begin
            if (!check_stall) begin
               if (hit) begin
                  if (pend_ff) begin
                     ovalid_in = 1'b1;
                     out_in    = {4'd0, pend_data_ff};
                     last_in   = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_data_in = race_word;
               end
               if (!scan_last) idx_in = idx_ff + 1'b1;
            end
         end
         lcrd_pkg::ST_DONE: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               out_in    = pend_ff ? {4'd0, pend_data_ff} : {4'd0, tag_ff, 20'd0};
               last_in   = 1'b1;
               pend_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lcrd_pkg::ST_CLEAR;
         clr_ff    <= '0;
         pend_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < THREADS; i++) locks_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
         if (accept && in_ok) begin
            if (in_cmd == lcrd_pkg::CMD_ACQUIRE && locks_ff[in_t] != '1)
               locks_ff[in_t] <= locks_ff[in_t] + 1'b1;
            if (in_cmd == lcrd_pkg::CMD_RELEASE && locks_ff[in_t] != '0)
               locks_ff[in_t] <= locks_ff[in_t] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff       <= out_in;
      last_ff      <= last_in;
      idx_ff       <= idx_in;
      pend_data_ff <= pend_data_in;
      if (accept) begin
         cmd_ff    <= in_cmd;
         thr_ff    <= in_t;
         ent_ff    <= EB'(in_ent);
         tag_ff    <= req_tdata[26:11];
         nolock_ff <= (locks_ff[in_t] == '0);
         for (int i = 0; i < THREADS; i++)
            vc_ff[i] <= (i < lcrd_pkg::CLOCK_INPUTS) ?
                        CLOCK_BITS'(req_tdata[27 + 32*(i % lcrd_pkg::CLOCK_INPUTS) +: 32]) :
                        '0;
      end
   end
endmodule
